// ----- rtl/srb_pkg.sv -----
// Shared types and constants of the sequence reorder buffer.
package srb_pkg;

    // Reorder window in frames. The slot of a frame is its index modulo the window,
    // so the window is kept a power of two.
    localparam int WINDOW = 16;
    localparam int SLOT_W = $clog2(WINDOW);

    // Field widths.
    localparam int IDX_W = 32;
    localparam int TAG_W = 32;
    localparam int STAT_W = 2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_RELEASED = 2'd0;
    localparam logic [STAT_W-1:0] ST_LATE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BEYOND = 2'd2;

    // Classification of an accepted frame.
    typedef logic [1:0] t_kind;
    localparam t_kind K_RELEASE = 2'd0;
    localparam t_kind K_LATE = 2'd1;
    localparam t_kind K_BEYOND = 2'd2;
    localparam t_kind K_BUFFER = 2'd3;

    // One classified frame on its way from the front end to the back end.
    typedef struct packed {
        t_kind kind;
        logic [IDX_W-1:0] index;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage

// ----- rtl/srb_front.sv -----
// Front end: accepts frames and classifies them against the expected index.
module srb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [63:0]                 i_s_tdata,
    input  logic [srb_pkg::IDX_W-1:0]   i_expected,
    input  logic                        i_release_done,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output srb_pkg::t_entry             o_q_entry
);

    logic                      r_rel_pending;
    logic                      n_rel_pending;
    logic [srb_pkg::IDX_W-1:0] seq_index;
    logic [srb_pkg::TAG_W-1:0] image_tag;
    logic [srb_pkg::IDX_W-1:0] ahead;
    srb_pkg::t_kind            kind;
    logic                      accept;

    assign seq_index = i_s_tdata[31:0];
    assign image_tag = i_s_tdata[63:32];

    // A release moves the expected index, so nothing new is classified until it drains.
    assign o_s_tready = !r_rel_pending && !i_q_full;
    assign accept = i_s_tvalid && o_s_tready;

    // Classify the frame by its distance from the expected index.
    assign ahead = seq_index - i_expected;
    always_comb begin
        if (seq_index < i_expected) begin
            kind = srb_pkg::K_LATE;
        end else if (ahead >= srb_pkg::IDX_W'(srb_pkg::WINDOW)) begin
            kind = srb_pkg::K_BEYOND;
        end else if (ahead != '0) begin
            kind = srb_pkg::K_BUFFER;
        end else begin
            kind = srb_pkg::K_RELEASE;
        end
    end

    assign o_q_push = accept;
    assign o_q_entry = '{kind: kind, index: seq_index, tag: image_tag};

    // Track the one release that may be in flight.
    always_comb begin
        n_rel_pending = r_rel_pending;
        if (accept && kind == srb_pkg::K_RELEASE) begin
            n_rel_pending = 1'b1;
        end else if (i_release_done) begin
            n_rel_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_rel_pending <= 1'b0;
        end else begin
            r_rel_pending <= n_rel_pending;
        end
    end

endmodule

// ----- rtl/srb_queue.sv -----
// Two-entry queue of classified frames between the front and back ends.
module srb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_push,
    input  srb_pkg::t_entry i_entry,
    input  logic            i_pop,
    output srb_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);

    srb_pkg::t_entry r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10: r_count <= r_count + 2'd1;
                2'b01: r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- rtl/srb_back.sv -----
// Back end: buffers frames in slots, issues results and drains in-order frames.
module srb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [srb_pkg::IDX_W-1:0]   i_cfg_wdata,
    input  srb_pkg::t_entry             i_q_entry,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    output logic [srb_pkg::IDX_W-1:0]   o_expected,
    output logic                        o_release_done,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [63:0]                 o_m_tdata,
    output logic [1:0]                  o_m_tuser,
    output logic                        o_m_tlast
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic                       r_state;
    logic                       n_state;
    logic [srb_pkg::IDX_W-1:0]  r_exp;
    logic [srb_pkg::IDX_W-1:0]  n_exp;
    logic [srb_pkg::WINDOW-1:0] r_slot_valid;
    logic [srb_pkg::WINDOW-1:0] n_slot_valid;
    logic [srb_pkg::TAG_W-1:0]  r_slot_tag [srb_pkg::WINDOW];

    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [srb_pkg::IDX_W-1:0]  r_out_index;
    logic [srb_pkg::IDX_W-1:0]  n_out_index;
    logic [srb_pkg::TAG_W-1:0]  r_out_tag;
    logic [srb_pkg::TAG_W-1:0]  n_out_tag;
    logic [srb_pkg::STAT_W-1:0] r_out_status;
    logic [srb_pkg::STAT_W-1:0] n_out_status;
    logic                       r_out_last;
    logic                       n_out_last;

    logic                       out_free;
    logic                       load;
    logic                       tag_we;
    logic [srb_pkg::SLOT_W-1:0] tag_addr;
    logic [srb_pkg::IDX_W-1:0]  exp_p1;
    logic [srb_pkg::SLOT_W-1:0] s_cur;
    logic [srb_pkg::SLOT_W-1:0] s_nxt;

    assign exp_p1 = r_exp + srb_pkg::IDX_W'(1);
    assign s_cur = r_exp[srb_pkg::SLOT_W-1:0];
    assign s_nxt = exp_p1[srb_pkg::SLOT_W-1:0];
    assign tag_addr = i_q_entry.index[srb_pkg::SLOT_W-1:0];

    // The output register can take a new result when it is empty or being taken.
    assign out_free = !r_out_valid || i_m_tready;

    // Sequencer: one queue entry or one drained slot per cycle, but a result waits for a free output register.
    always_comb begin
        n_state = r_state;
        n_exp = r_exp;
        n_slot_valid = r_slot_valid;
        n_out_index = r_out_index;
        n_out_tag = r_out_tag;
        n_out_status = r_out_status;
        n_out_last = r_out_last;
        o_q_pop = 1'b0;
        o_release_done = 1'b0;
        tag_we = 1'b0;
        load = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_entry.kind)
                        srb_pkg::K_BUFFER: begin
                            // Hold the frame; a duplicate overwrites the slot.
                            o_q_pop = 1'b1;
                            tag_we = 1'b1;
                            n_slot_valid[tag_addr] = 1'b1;
                        end
                        srb_pkg::K_LATE, srb_pkg::K_BEYOND: begin
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                load = 1'b1;
                                n_out_index = i_q_entry.index;
                                n_out_tag = i_q_entry.tag;
                                n_out_status = (i_q_entry.kind == srb_pkg::K_LATE) ?
                                    srb_pkg::ST_LATE : srb_pkg::ST_BEYOND;
                                n_out_last = 1'b1;
                            end
                        end
                        default: begin
                            // In-order frame: release it and look at the next slot.
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                load = 1'b1;
                                n_out_index = i_q_entry.index;
                                n_out_tag = i_q_entry.tag;
                                n_out_status = srb_pkg::ST_RELEASED;
                                n_out_last = !r_slot_valid[s_nxt];
                                n_exp = exp_p1;
                                if (r_slot_valid[s_nxt]) begin
                                    n_state = S_DRAIN;
                                end else begin
                                    o_release_done = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                // Drain the buffered frame at the expected index.
                if (out_free) begin
                    load = 1'b1;
                    n_out_index = r_exp;
                    n_out_tag = r_slot_tag[s_cur];
                    n_out_status = srb_pkg::ST_RELEASED;
                    n_out_last = !r_slot_valid[s_nxt];
                    n_slot_valid[s_cur] = 1'b0;
                    n_exp = exp_p1;
                    if (!r_slot_valid[s_nxt]) begin
                        n_state = S_IDLE;
                        o_release_done = 1'b1;
                    end
                end
            end
        endcase

        n_out_valid = load || (r_out_valid && !i_m_tready);
    end

    // Control state; a configuration write reloads the expected index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_exp <= '0;
            r_slot_valid <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_we) begin
            r_state <= S_IDLE;
            r_exp <= i_cfg_wdata;
            r_slot_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_exp <= n_exp;
            r_slot_valid <= n_slot_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Slot handles and the result register.
    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_slot_tag[tag_addr] <= i_q_entry.tag;
        end
        r_out_index <= n_out_index;
        r_out_tag <= n_out_tag;
        r_out_status <= n_out_status;
        r_out_last <= n_out_last;
    end

    assign o_expected = r_exp;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = {r_out_tag, r_out_index};
    assign o_m_tuser = r_out_status;
    assign o_m_tlast = r_out_last;

endmodule

// ----- rtl/sequence_reorder_buffer.sv -----
// Top level of the sequence reorder buffer: front end, queue and back end.
//
//  Channel  Direction  Content
//  s        in         tdata = seq_index, image_tag
//  m        out        tdata = out_index, out_tag; tuser = status; tlast = last
//  cfg      in         i_cfg_wdata = first_index, written when i_cfg_we is high
//
// The front end takes one frame per cycle while the two-entry queue has room.
// The back end handles one queue entry or drained frame per cycle, but a result waits
// for a free output register. A release occupies the back end until its drain ends.
// After an in-order frame the input stalls until its drain has finished.
// Reset and a first_index write clear all slots and reload the expected index.
// A stalled output holds its result while the front end keeps filling the queue.
module sequence_reorder_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] seq_index, [63:32] image_tag
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] out_index, [63:32] out_tag
    output logic [1:0]  o_m_tuser,   // [1:0] status
    output logic        o_m_tlast
);

    srb_pkg::t_entry           push_entry;
    srb_pkg::t_entry           head_entry;
    logic                      q_push;
    logic                      q_pop;
    logic                      q_full;
    logic                      q_empty;
    logic                      release_done;
    logic [srb_pkg::IDX_W-1:0] expected;

    // Accept and classify frames.
    srb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_expected     (expected),
        .i_release_done (release_done),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_entry      (push_entry)
    );

    // Decouple classification from execution.
    srb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_entry (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Buffer, release and drain.
    srb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_entry      (head_entry),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .o_expected     (expected),
        .o_release_done (release_done),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_tdata      (o_m_tdata),
        .o_m_tuser      (o_m_tuser),
        .o_m_tlast      (o_m_tlast)
    );

endmodule

// ----- sim/testbench.sv -----
// Testbench of the sequence reorder buffer: random and directed frames against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD_CYCLES = 300;

    // One result as it leaves the block.
    typedef struct {
        logic [srb_pkg::IDX_W-1:0]  index;
        logic [srb_pkg::TAG_W-1:0]  tag;
        logic [srb_pkg::STAT_W-1:0] status;
        logic                       last;
    } t_frame_result;

    // Predicts released and dropped frames and checks them in order.
    class reorder_scoreboard;
        logic [srb_pkg::IDX_W-1:0] next_index;
        bit                        held[srb_pkg::WINDOW];
        logic [srb_pkg::TAG_W-1:0] held_tag[srb_pkg::WINDOW];
        t_frame_result             due_results[$];
        int                        mismatches;

        function new();
            mismatches = 0;
            load_first(32'h0000_0000);
        endfunction

        function void load_first(logic [srb_pkg::IDX_W-1:0] value);
            next_index = value;
            for (int i = 0; i < srb_pkg::WINDOW; i++) begin
                held[i] = 1'b0;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void push_result(logic [srb_pkg::IDX_W-1:0] index,
                                  logic [srb_pkg::TAG_W-1:0] tag,
                                  logic [srb_pkg::STAT_W-1:0] status, logic last);
            t_frame_result r;
            r.index = index;
            r.tag = tag;
            r.status = status;
            r.last = last;
            due_results.push_back(r);
        endfunction

        // Works out the results that one accepted frame causes.
        function void note_frame(logic [srb_pkg::IDX_W-1:0] index,
                                 logic [srb_pkg::TAG_W-1:0] tag);
            logic [srb_pkg::IDX_W-1:0]  ahead;
            logic [srb_pkg::SLOT_W-1:0] slot;
            t_frame_result              r;
            int                         count;
            ahead = index - next_index;
            if (index < next_index) begin
                push_result(index, tag, srb_pkg::ST_LATE, 1'b1);
            end else if (ahead >= srb_pkg::WINDOW) begin
                push_result(index, tag, srb_pkg::ST_BEYOND, 1'b1);
            end else if (ahead != 0) begin
                slot = index[srb_pkg::SLOT_W-1:0];
                held[slot] = 1'b1;
                held_tag[slot] = tag;
            end else begin
                push_result(index, tag, srb_pkg::ST_RELEASED, 1'b0);
                next_index = next_index + 1;
                count = 1;
                // Drain the held frames that now follow in sequence.
                while (count < srb_pkg::WINDOW && held[next_index[srb_pkg::SLOT_W-1:0]]) begin
                    slot = next_index[srb_pkg::SLOT_W-1:0];
                    push_result(next_index, held_tag[slot], srb_pkg::ST_RELEASED, 1'b0);
                    held[slot] = 1'b0;
                    next_index = next_index + 1;
                    count++;
                end
                r = due_results.pop_back();
                r.last = 1'b1;
                due_results.push_back(r);
            end
        endfunction

        task report(string line);
            mismatches++;
            if (mismatches <= 60) begin
                $display("mismatch: %s", line);
            end
        endtask

        // Compares one result transfer with the oldest expectation.
        task check_result(logic [srb_pkg::IDX_W-1:0] index, logic [srb_pkg::TAG_W-1:0] tag,
                          logic [srb_pkg::STAT_W-1:0] status, logic last);
            t_frame_result want;
            if (due_results.size() == 0) begin
                report($sformatf("result index %h tag %h with no frame waiting", index, tag));
            end else begin
                want = due_results.pop_front();
                if (index !== want.index) begin
                    report($sformatf("index got %h, expected %h", index, want.index));
                end
                if (tag !== want.tag) begin
                    report($sformatf("tag of %h got %h, expected %h", want.index, tag,
                                     want.tag));
                end
                if (status !== want.status) begin
                    report($sformatf("status of %h got %0d, expected %0d", want.index,
                                     status, want.status));
                end
                if (last !== want.last) begin
                    report($sformatf("last of %h got %b, expected %b", want.index, last,
                                     want.last));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    reorder_scoreboard sb = new();

    logic [srb_pkg::IDX_W-1:0] gen_base;
    bit                        long_hold_req = 1'b0;
    int                        idle_cycles = 0;

    sequence_reorder_buffer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sequence_reorder_buffer verification failed");
            $finish;
        end
    end

    // Result side: random hold-offs between transfers, with bursts of none.
    initial begin : result_sink
        int gap;
        bit burst;
        burst = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                burst = !burst;
            end
            gap = burst ? 0 : $urandom_range(0, 12);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                gap = LONG_HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            sb.check_result(o_m_tdata[31:0], o_m_tdata[63:32], o_m_tuser, o_m_tlast);
        end
    end

    // Offers one frame after a random gap and notes it once the transfer happens.
    task automatic send_frame(logic [srb_pkg::IDX_W-1:0] index, logic [srb_pkg::TAG_W-1:0] tag);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {tag, index};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_frame(index, tag);
    endtask

    // Waits until the block is idle, then loads the expected index.
    task automatic load_first_index(logic [srb_pkg::IDX_W-1:0] value);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.load_first(value);
        gen_base = value;
    endtask

    // A frame that is late, beyond the window or anywhere at all.
    task automatic send_stray();
        logic [srb_pkg::IDX_W-1:0] index;
        case ($urandom_range(0, 3))
            0: index = gen_base - 1 - $urandom_range(0, 40);
            1: index = gen_base + srb_pkg::WINDOW + $urandom_range(0, 2000);
            2: index = gen_base + srb_pkg::WINDOW + 15;
            default: index = $urandom;
        endcase
        send_frame(index, $urandom);
    endtask

    // Sends a run of consecutive indices in shuffled order, with strays and
    // duplicates mixed in; a broken run leaves one index out.
    task automatic send_run(int n, bit broken);
        logic [srb_pkg::IDX_W-1:0] order[srb_pkg::WINDOW];
        logic [srb_pkg::IDX_W-1:0] swap;
        int                        j;
        int                        skip;
        for (int i = 0; i < n; i++) begin
            order[i] = gen_base + i;
        end
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        skip = broken ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_stray();
            end
            if (i != skip) begin
                send_frame(order[i], $urandom);
                if ($urandom_range(0, 7) == 0) begin
                    send_frame(order[i], $urandom);
                end
            end
        end
        gen_base = gen_base + n;
    endtask

    initial begin : stimulus
        logic [srb_pkg::IDX_W-1:0] phase_first[4];
        int                        runs;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: release, late, just beyond, the far end of the window,
        // a full window drained by one frame, a duplicate, the top index.
        load_first_index(32'h0000_0000);
        send_frame(32'd0, 32'h0000_0000);
        send_frame(32'd0, 32'hFFFF_FFFF);
        send_frame(32'd17, 32'h1234_5678);
        send_frame(32'd16, 32'hFFFF_FFFF);
        for (int i = 15; i >= 2; i--) begin
            send_frame(i, 32'hA5A5_0000 | i);
        end
        send_frame(32'd7, 32'h5A5A_5A5A);
        send_frame(32'd1, 32'h8000_0001);
        send_frame(32'hFFFF_FFFF, 32'h0F0F_F0F0);
        send_frame(32'd17, 32'h0000_0000);

        // Random phases at the extremes, across the wrap and anywhere.
        phase_first[0] = 32'hFFFF_FFFF;
        phase_first[1] = 32'hFFFF_FFF5;
        phase_first[2] = $urandom;
        phase_first[3] = 32'h8000_0000;
        for (int p = 0; p < 4; p++) begin
            load_first_index(phase_first[p]);
            if (p == 1) begin
                long_hold_req = 1'b1;
            end
            runs = 0;
            while (runs < 3) begin
                send_run($urandom_range(1, srb_pkg::WINDOW - 4), 1'b0);
                runs++;
            end
            send_run($urandom_range(2, srb_pkg::WINDOW), (p % 2) == 0);
        end
        i_s_tvalid <= 1'b0;

        // Wait for the last results, then for anything stray.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("sequence_reorder_buffer verification clean");
        end else begin
            $display("sequence_reorder_buffer verification failed");
        end
        $finish;
    end

endmodule
